// ===== hdl/circular_deque_unit_defines.svh =====
// Assertion macros for the circular deque unit.
// Used by the top level; needs clk_i and rst_ni in scope where expanded.
`ifndef CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cdq_pkg.sv =====
// Shared types, codes and pointer helpers for the circular deque unit.
// No dependencies; imported by cdq_ctrl, cdq_datapath and the top level.
`default_nettype none

package cdq_pkg;

  localparam int unsigned Depth = 32;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned DataW = 32;

  typedef logic [PtrW-1:0] ptr_t;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_REAR   = 3'd3;
  localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [2:0] CMD_PEEK_REAR  = 3'd5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] item;
  } cdq_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    status_e            status;
    logic [4:0]         count;
    logic               is_empty_flag;
    logic               is_full_flag;
  } cdq_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the request beat
    logic exec;        // update pointers, access the slot store, load status
    logic load_value;  // take the read data into the result
  } cdq_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic rd_op;       // captured command reads a slot and is legal
  } cdq_stat_t;

  function automatic ptr_t ring_next(ptr_t p);
    return (p == ptr_t'(Depth - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t ring_prev(ptr_t p);
    return (p == '0) ? ptr_t'(Depth - 1) : p - ptr_t'(1);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cdq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/cdq_ctrl.sv =====
// Command sequencer for the circular deque unit.
// Depends on cdq_pkg for the control and status structs.
`default_nettype none

module cdq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire cdq_pkg::cdq_stat_t stat_i,
  output cdq_pkg::cdq_ctrl_t     ctrl_o,
  output logic                   busy_o,
  output logic                   done_o
);
  import cdq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (stat_i.rd_op) begin
            state_q <= S_READ;
          end else begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        S_READ: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    ctrl_o.load       = (state_q == S_IDLE) && start_i;
    ctrl_o.exec       = (state_q == S_EXEC);
    ctrl_o.load_value = (state_q == S_READ);
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== hdl/cdq_datapath.sv =====
// Pointers, slot store and result register of the circular deque unit.
// Depends on cdq_pkg and instantiates cdq_ram for the slots.
`default_nettype none

module cdq_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cdq_pkg::cdq_req_t  req_i,
  input  wire cdq_pkg::cdq_ctrl_t ctrl_i,
  output cdq_pkg::cdq_stat_t      stat_o,
  output cdq_pkg::cdq_rsp_t       rsp_o
);
  import cdq_pkg::*;

  localparam logic [PtrW:0] DepthExt = (PtrW + 1)'(Depth);

  cdq_req_t req_q;
  ptr_t     front_q, front_d;
  ptr_t     rear_q, rear_d;
  cdq_rsp_t rsp_q;

  logic       is_push, is_read, is_front;
  logic       empty_now, full_now;
  logic       push_ok, read_ok;
  status_e    status_d;
  logic [PtrW:0] cnt_d;
  ptr_t       waddr, raddr;
  logic [DataW-1:0] rdata;

  always_comb begin
    is_push  = (req_q.cmd == CMD_PUSH_FRONT) || (req_q.cmd == CMD_PUSH_REAR);
    is_read  = req_q.cmd inside {[CMD_POP_FRONT:CMD_PEEK_REAR]};
    is_front = req_q.cmd inside {CMD_PUSH_FRONT, CMD_POP_FRONT, CMD_PEEK_FRONT};

    empty_now = (front_q == rear_q);
    full_now  = (ring_next(rear_q) == front_q);
    push_ok   = is_push && !full_now;
    read_ok   = is_read && !empty_now;

    if (is_push && full_now) begin
      status_d = ST_FULL;
    end else if (is_read && empty_now) begin
      status_d = ST_EMPTY;
    end else begin
      status_d = ST_OK;
    end

    front_d = front_q;
    rear_d  = rear_q;
    case (req_q.cmd)
      CMD_PUSH_FRONT: if (push_ok) front_d = ring_prev(front_q);
      CMD_PUSH_REAR:  if (push_ok) rear_d  = ring_next(rear_q);
      CMD_POP_FRONT:  if (read_ok) front_d = ring_next(front_q);
      CMD_POP_REAR:   if (read_ok) rear_d  = ring_prev(rear_q);
      default: ;
    endcase

    if (rear_d >= front_d) begin
      cnt_d = {1'b0, rear_d} - {1'b0, front_d};
    end else begin
      cnt_d = {1'b0, rear_d} + DepthExt - {1'b0, front_d};
    end

    // front push writes the sentinel slot; rear push the slot after the last
    waddr = is_front ? front_q : ring_next(rear_q);
    raddr = is_front ? ring_next(front_q) : rear_q;
  end

  cdq_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.exec && push_ok),
    .waddr_i (waddr),
    .wdata_i (req_q.item),
    .re_i    (ctrl_i.exec && read_ok),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
    end else if (ctrl_i.exec) begin
      front_q <= front_d;
      rear_q  <= rear_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_q <= req_i;
    end
    if (ctrl_i.exec) begin
      rsp_q.value         <= '0;
      rsp_q.status        <= status_d;
      rsp_q.count         <= 5'(cnt_d);
      rsp_q.is_empty_flag <= (front_d == rear_d);
      rsp_q.is_full_flag  <= (ring_next(rear_d) == front_d);
    end else if (ctrl_i.load_value) begin
      rsp_q.value <= $signed(rdata);
    end
  end

  assign stat_o.rd_op = read_ok;
  assign rsp_o        = rsp_q;

endmodule

`default_nettype wire

// ===== hdl/circular_deque_unit.sv =====
// Circular deque unit: ring-buffer double-ended queue of 32-bit items.
//
// Request channel: req_i carries cmd and item; a beat is taken at a rising
// edge where start is high and busy is low. busy stays high until the
// result has been produced.
// Result channel: rsp_o carries value, status, count and the empty/full
// flags after the command; done_o marks it for exactly one cycle and the
// receiver takes it in that cycle. There is no back-pressure.
// From accept to done, pushes, errors and unused codes pass through
// S_EXEC only; legal pops and peeks also pass through S_READ, the extra
// state covering the registered read port of the slot RAM. A new request
// may be accepted in the cycle that done is high.
// The ring holds Depth slots and at most Depth-1 items; a push when full
// or a pop/peek when empty leaves the state alone and reports a status.
// Reset (rst_ni low) empties the deque at once: both pointers clear and no
// clearing pass over the slot RAM is needed.
`default_nettype none
`include "circular_deque_unit_defines.svh"

module circular_deque_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire cdq_pkg::cdq_req_t req_i,
  output logic                   done_o,
  output cdq_pkg::cdq_rsp_t      rsp_o
);
  import cdq_pkg::*;

  cdq_ctrl_t ctrl;
  cdq_stat_t stat;

  cdq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  cdq_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .rsp_o  (rsp_o)
  );

  `CDQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done_o,
                   "accepted beat did not raise busy")
  `CDQ_ASSERT_SAME(a_done_idle, done_o, !busy, "result emitted while still busy")
  `CDQ_ASSERT_SAME(a_err_zero, done_o && (rsp_o.status != ST_OK), rsp_o.value == '0,
                   "rejected command returned a non-zero value")
  `CDQ_ASSERT_SAME(a_flags_excl, done_o, !(rsp_o.is_empty_flag && rsp_o.is_full_flag),
                   "deque reported empty and full together")

endmodule

`default_nettype wire
